/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, held off while rst_ni is low
`define LSD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// same check under a name that states it covers the emit path
`define LSD_ASSERT_EMIT(name, prop) `LSD_ASSERT(name, prop)

`endif

/* rtl/lsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_pkg
// Types and constants of the led / solenoid command deframer.
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam int MaxLeds    = 7;
  localparam int StoreDepth = 4 * MaxLeds;
  localparam int RowW       = $clog2(MaxLeds);
  localparam int CntW       = $clog2(MaxLeds + 1);
  localparam int SeenW      = $clog2(StoreDepth + 1);

  // command bytes
  localparam logic [7:0] ChDump = 8'h44;  // 'D'
  localparam logic [7:0] ChOff  = 8'h46;  // 'F'
  localparam logic [7:0] ChSol  = 8'h53;  // 'S'
  localparam logic [7:0] ChLed  = 8'h4C;  // 'L'
  localparam logic [7:0] ChFade = 8'h6C;  // 'l'

  typedef enum logic [2:0] {
    ACT_DUMP     = 3'd0,
    ACT_OFF      = 3'd1,
    ACT_SOLENOID = 3'd2,
    ACT_SET_LED  = 3'd3,
    ACT_FADE_LED = 3'd4,
    ACT_UNKNOWN  = 3'd5,
    ACT_OVERSIZE = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    CC_DUMP,
    CC_OFF,
    CC_SOL,
    CC_LED,
    CC_FADE,
    CC_OTHER
  } cmd_code_e;

  typedef enum logic [2:0] {
    IT_DUMP,
    IT_OFF,
    IT_SOL,
    IT_UNKNOWN,
    IT_OVERSIZE,
    IT_LED_EMPTY,
    IT_LED
  } item_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SOL,
    PH_LCNT,
    PH_DUR,
    PH_FCNT,
    PH_DATA,
    PH_READ,
    PH_SEND
  } phase_e;

  typedef struct packed {
    logic  load_out;
    item_e item;
    logic  clr_fade;
    logic  set_fade;
    logic  load_dur;
    logic  load_count;
    logic  store_wr;
    logic  idx_clr;
    logic  rd_row;
    logic  idx_inc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic      out_free;
    cmd_code_e code;
    logic      cnt_over;
    logic      cnt_zero;
    logic      data_done;
    logic      idx_last;
  } dp_stat_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] arg;
    logic [2:0] led_count;
    logic [2:0] led_index;
    logic [7:0] led_byte0;
    logic [7:0] led_byte1;
    logic [7:0] led_byte2;
    logic [7:0] led_byte3;
    logic       last;
  } result_t;

endpackage

/* rtl/lsd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_if
// Valid / ready channels of the deframer: received bytes and result words.
// ----------------------------------------------------------------------------
interface lsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lsd_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] arg;
  logic [2:0] led_count;
  logic [2:0] led_index;
  logic [7:0] led_byte0;
  logic [7:0] led_byte1;
  logic [7:0] led_byte2;
  logic [7:0] led_byte3;
  logic       last;

  modport source (output valid, output action, output arg, output led_count,
                  output led_index, output led_byte0, output led_byte1,
                  output led_byte2, output led_byte3, output last, input ready);
  modport sink   (input valid, input action, input arg, input led_count,
                  input led_index, input led_byte0, input led_byte1,
                  input led_byte2, input led_byte3, input last, output ready);
endinterface

/* rtl/lsd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_datapath
// Command fields, led byte store, store read register and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsd_datapath import lsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_stat_t   stat_o,
  input  logic       res_ready_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic             is_fade_q;
  logic [7:0]       fade_time_q;
  logic [CntW-1:0]  count_q;
  logic [SeenW-1:0] seen_q;
  logic [SeenW-1:0] seen_inc;
  logic [RowW-1:0]  idx_q;
  logic [3:0][7:0]  store_q [MaxLeds];
  logic [3:0][7:0]  rd_q;
  logic             out_valid_q;
  result_t          out_q;
  result_t          item_d;
  logic [RowW-1:0]  wr_row;
  logic             idx_last;
  logic             out_free;
  cmd_code_e        code;

  assign seen_inc = seen_q + SeenW'(1);
  assign wr_row   = seen_q[2 +: RowW];
  assign idx_last = ({1'b0, idx_q} + (RowW + 1)'(1)) == (RowW + 1)'(count_q);
  assign out_free = !out_valid_q || res_ready_i;

  always_comb begin
    unique case (rx_byte_i)
      ChDump:  code = CC_DUMP;
      ChOff:   code = CC_OFF;
      ChSol:   code = CC_SOL;
      ChLed:   code = CC_LED;
      ChFade:  code = CC_FADE;
      default: code = CC_OTHER;
    endcase
  end

  assign stat_o.code      = code;
  assign stat_o.out_free  = out_free;
  assign stat_o.cnt_over  = rx_byte_i > 8'(MaxLeds);
  assign stat_o.cnt_zero  = rx_byte_i == 8'd0;
  assign stat_o.data_done = (seen_inc >= SeenW'({count_q, 2'b00}))
                         || (seen_inc >= SeenW'(StoreDepth));
  assign stat_o.idx_last  = idx_last;

  always_comb begin
    item_d      = '0;
    item_d.last = 1'b1;
    unique case (cmd_i.item)
      IT_DUMP: item_d.action = ACT_DUMP;
      IT_OFF:  item_d.action = ACT_OFF;
      IT_SOL: begin
        item_d.action = ACT_SOLENOID;
        item_d.arg    = rx_byte_i;
      end
      IT_UNKNOWN: begin
        item_d.action = ACT_UNKNOWN;
        item_d.arg    = rx_byte_i;
      end
      IT_OVERSIZE: begin
        item_d.action = ACT_OVERSIZE;
        item_d.arg    = rx_byte_i;
      end
      IT_LED_EMPTY: begin
        item_d.action = is_fade_q ? ACT_FADE_LED : ACT_SET_LED;
        item_d.arg    = is_fade_q ? fade_time_q : 8'd0;
      end
      IT_LED: begin
        item_d.action    = is_fade_q ? ACT_FADE_LED : ACT_SET_LED;
        item_d.arg       = is_fade_q ? fade_time_q : 8'(count_q);
        item_d.led_count = 3'(count_q);
        item_d.led_index = 3'(idx_q);
        item_d.led_byte0 = rd_q[0];
        item_d.led_byte1 = rd_q[1];
        item_d.led_byte2 = rd_q[2];
        item_d.led_byte3 = rd_q[3];
        item_d.last      = idx_last;
      end
      default: item_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_fade_q   <= 1'b0;
      fade_time_q <= '0;
      count_q     <= '0;
      seen_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.set_fade) begin
        is_fade_q <= 1'b1;
      end else if (cmd_i.clr_fade) begin
        is_fade_q <= 1'b0;
      end
      if (cmd_i.load_dur) begin
        fade_time_q <= rx_byte_i;
      end
      if (cmd_i.load_count) begin
        count_q <= rx_byte_i[CntW-1:0];
        seen_q  <= '0;
      end else if (cmd_i.store_wr) begin
        seen_q <= seen_inc;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + RowW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // store bytes kept shifted left by one, top bit dropped
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      store_q[wr_row][seen_q[1:0]] <= {rx_byte_i[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_row) begin
      rd_q <= store_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= item_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  `LSD_ASSERT(a_seen_in_range, seen_q <= SeenW'(StoreDepth))
  `LSD_ASSERT_EMIT(a_index_below_count,
    (out_valid_q && out_q.led_count != 3'd0) |-> (out_q.led_index < out_q.led_count))

endmodule

/* rtl/lsd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsd_ctrl
// Framing state machine: walks the command bytes and steps the led emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsd_ctrl import lsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rx_valid_i,
  output logic      rx_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  phase_e phase_q;
  phase_e phase_d;
  logic   accept;

  assign rx_ready_o = (phase_q != PH_READ) && (phase_q != PH_SEND) && stat_i.out_free;
  assign accept     = rx_valid_i && rx_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    cmd_o   = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if (accept) begin
          unique case (stat_i.code)
            CC_DUMP: begin
              cmd_o.load_out = 1'b1;
              cmd_o.item     = IT_DUMP;
            end
            CC_OFF: begin
              cmd_o.load_out = 1'b1;
              cmd_o.item     = IT_OFF;
            end
            CC_SOL: phase_d = PH_SOL;
            CC_LED: begin
              cmd_o.clr_fade = 1'b1;
              phase_d        = PH_LCNT;
            end
            CC_FADE: begin
              cmd_o.set_fade = 1'b1;
              phase_d        = PH_DUR;
            end
            default: begin
              cmd_o.load_out = 1'b1;
              cmd_o.item     = IT_UNKNOWN;
            end
          endcase
        end
      end
      PH_SOL: begin
        if (accept) begin
          cmd_o.load_out = 1'b1;
          cmd_o.item     = IT_SOL;
          phase_d        = PH_IDLE;
        end
      end
      PH_DUR: begin
        if (accept) begin
          cmd_o.load_dur = 1'b1;
          phase_d        = PH_FCNT;
        end
      end
      PH_LCNT, PH_FCNT: begin
        if (accept) begin
          priority if (stat_i.cnt_over) begin
            cmd_o.load_out = 1'b1;
            cmd_o.item     = IT_OVERSIZE;
            phase_d        = PH_IDLE;
          end else if (stat_i.cnt_zero) begin
            cmd_o.load_count = 1'b1;
            cmd_o.load_out   = 1'b1;
            cmd_o.item       = IT_LED_EMPTY;
            phase_d          = PH_IDLE;
          end else begin
            cmd_o.load_count = 1'b1;
            phase_d          = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (accept) begin
          cmd_o.store_wr = 1'b1;
          if (stat_i.data_done) begin
            cmd_o.idx_clr = 1'b1;
            phase_d       = PH_READ;
          end
        end
      end
      PH_READ: begin
        cmd_o.rd_row = 1'b1;
        phase_d      = PH_SEND;
      end
      PH_SEND: begin
        // one led word per store row, waits for the result register
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.item     = IT_LED;
          cmd_o.idx_inc  = 1'b1;
          phase_d        = stat_i.idx_last ? PH_IDLE : PH_READ;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  `LSD_ASSERT(a_load_needs_free, cmd_o.load_out |-> stat_i.out_free)
  `LSD_ASSERT_EMIT(a_read_then_send, (phase_q == PH_READ) |=> (phase_q == PH_SEND))
  `LSD_ASSERT_EMIT(a_last_to_idle,
    (phase_q == PH_SEND && stat_i.out_free && stat_i.idx_last) |=> (phase_q == PH_IDLE))

endmodule

/* rtl/led_solenoid_command_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_solenoid_command_deframer
// Frames dump, off, solenoid, set-led and fade-led commands from a byte
// stream and emits result words, one per led for led commands with a nonzero count.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                         accepted when
//  rx_i     in   rx_byte                                         valid && ready
//  res_o    out  action arg led_count led_index led_byte0..3 last valid && ready
//
//  a byte is taken whenever the result register is free or drained in that
//  cycle and no led words are being emitted; bytes that only advance framing
//  never wait on anything else; a completed led command with n leds emits n
//  words (store row read, then result register load) and holds rx till done
//  reset is asynchronous, active low; the led store is not cleared
//  res_o.ready low holds a valid result word and, while one is held, keeps rx_i.ready low
// ----------------------------------------------------------------------------
module led_solenoid_command_deframer import lsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsd_rx_if.sink     rx_i,
  lsd_res_if.source  res_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  result_t   item;
  logic      res_valid;

  lsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_i.valid),
    .rx_ready_o (rx_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lsd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_i.rx_byte),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_valid),
    .res_o       (item)
  );

  assign res_o.valid     = res_valid;
  assign res_o.action    = item.action;
  assign res_o.arg       = item.arg;
  assign res_o.led_count = item.led_count;
  assign res_o.led_index = item.led_index;
  assign res_o.led_byte0 = item.led_byte0;
  assign res_o.led_byte1 = item.led_byte1;
  assign res_o.led_byte2 = item.led_byte2;
  assign res_o.led_byte3 = item.led_byte3;
  assign res_o.last      = item.last;

endmodule
